### hdl/sgfd_pkg.sv
// -----------------------------------------------------------------------------
// Sensor grid deframer package
// Result kinds, framing bytes, status tags, the token layout lookup and the
// command and status bundles between the controller and the datapath.
// -----------------------------------------------------------------------------
package sgfd_pkg;

   localparam logic [2:0] KIND_PIXEL     = 3'd0;
   localparam logic [2:0] KIND_ACCEPT    = 3'd1;
   localparam logic [2:0] KIND_CK_DROP   = 3'd2;
   localparam logic [2:0] KIND_UNCHECKED = 3'd3;
   localparam logic [2:0] KIND_SYNC_LOST = 3'd4;

   localparam logic [7:0] BYTE_SYNC = 8'hFF;
   localparam logic [7:0] BYTE_ZERO = 8'h00;

   localparam logic [7:0] TAG_NONE = 8'h00;
   localparam logic [7:0] TAG_V    = 8'h56;
   localparam logic [7:0] TAG_S    = 8'h53;
   localparam logic [7:0] TAG_I    = 8'h49;
   localparam logic [7:0] TAG_M    = 8'h4D;
   localparam logic [7:0] TAG_F    = 8'h46;
   localparam logic [7:0] TAG_W    = 8'h57;
   localparam logic [7:0] TAG_H    = 8'h48;
   localparam logic [7:0] TAG_G    = 8'h47;
   localparam logic [7:0] TAG_N    = 8'h4E;
   localparam logic [7:0] TAG_X    = 8'h58;
   localparam logic [7:0] TAG_XL   = 8'h78;
   localparam logic [7:0] TAG_C    = 8'h43;

   localparam logic [15:0] VERSION_BASE = 16'd260;
   localparam logic [15:0] VERSION_GRID = 16'd261;
   localparam logic [15:0] VERSION_MUX  = 16'd262;

   localparam logic [15:0] LEGACY_WIDTH  = 16'd20;
   localparam logic [15:0] LEGACY_HEIGHT = 16'd10;

   localparam logic [2:0] HEX_DIGITS = 3'd4;

   typedef struct packed {
      logic       load_byte;
      logic       sync_lost;
      logic       tag_start;
      logic       digit;
      logic       digit_last;
      logic       row_line;
      logic       pixel;
      logic       row_end;
      logic       div_start;
      logic       status_emit;
      logic [3:0] token_index;
   } sgfd_cmd_type;

   typedef struct packed {
      logic is_ff;
      logic is_zero;
      logic tag_ok;
      logic hex_ok;
      logic tok_err;
      logic tok_finish;
      logic line_ok;
      logic vpr_zero;
      logic data_last;
      logic line_last;
      logic div_busy;
      logic out_busy;
   } sgfd_stat_type;

   // Expected tag letter at a token slot for a firmware version
   function automatic logic [7:0] tag_for(input logic [15:0] version,
                                          input logic [3:0]  idx);
      logic [7:0] tag;
      tag = TAG_NONE;
      if (idx == 4'd0) begin
         tag = TAG_V;
      end else begin
         case (idx)
            4'd1: tag = TAG_S;
            4'd2: tag = TAG_I;
            4'd3: tag = TAG_M;
            4'd4: tag = TAG_F;
            4'd5: tag = TAG_W;
            4'd6: tag = TAG_H;
            default: tag = TAG_NONE;
         endcase
         if (version == VERSION_BASE) begin
            case (idx)
               4'd7: tag = TAG_N;
               4'd8: tag = TAG_C;
               default: ;
            endcase
         end else if (version == VERSION_GRID) begin
            case (idx)
               4'd7: tag = TAG_G;
               4'd8: tag = TAG_N;
               4'd9: tag = TAG_C;
               default: ;
            endcase
         end else if (version == VERSION_MUX) begin
            case (idx)
               4'd7:  tag = TAG_G;
               4'd8:  tag = TAG_N;
               4'd9:  tag = TAG_X;
               4'd10: tag = TAG_XL;
               4'd11: tag = TAG_C;
               default: ;
            endcase
         end
         if (version != VERSION_BASE && version != VERSION_GRID &&
             version != VERSION_MUX) begin
            tag = TAG_NONE;
         end else if (version == VERSION_BASE && idx > 4'd8) begin
            tag = TAG_NONE;
         end else if (version == VERSION_GRID && idx > 4'd9) begin
            tag = TAG_NONE;
         end else if (version == VERSION_MUX && idx > 4'd11) begin
            tag = TAG_NONE;
         end
      end
      return tag;
   endfunction

endpackage

### hdl/sgfd_if.sv
// -----------------------------------------------------------------------------
// Sensor grid deframer channels
// Valid/ready channels for received bytes and for deframed results.
// -----------------------------------------------------------------------------
interface sgfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface sgfd_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [5:0]  row;
   logic [5:0]  column;
   logic [7:0]  pixel;
   logic [15:0] frame_number;
   logic [15:0] firmware_version;
   logic [15:0] firmware_status;
   logic [15:0] controller_id;
   logic [15:0] firmware_mode;
   logic [15:0] frame_rate;
   logic [6:0]  grid_width;
   logic [6:0]  grid_height;

   modport source (output valid, output kind, output row, output column, output pixel,
                   output frame_number, output firmware_version, output firmware_status,
                   output controller_id, output firmware_mode, output frame_rate,
                   output grid_width, output grid_height, input ready);
   modport sink   (input valid, input kind, input row, input column, input pixel,
                   input frame_number, input firmware_version, input firmware_status,
                   input controller_id, input firmware_mode, input frame_rate,
                   input grid_width, input grid_height, output ready);
endinterface

### hdl/sensor_grid_frame_deframer.sv
// Timing: a taken byte beat is registered and examined once no result beat waits;
//   its result beat is registered, and for the byte that closes a status line only
//   after the width-by-multiplex divide has finished. A result beat not taken holds it.
// Flow: a new byte is taken only after the last one has been examined; the byte that
//   closes a status line also holds the byte channel for the width-by-multiplex divide.
// Reset (synchronous, active high) starts the hunt for 0xFF 0x00 with all
//   status fields, grid size and byte sum at zero and the first-frame flag set.
// -----------------------------------------------------------------------------
// Sensor grid frame deframer
// Deframes a serial sensor grid byte stream into pixel writes and per-frame
// status events (accepted, checksum drop, unchecked) or sync-lost events.
// -----------------------------------------------------------------------------
module sensor_grid_frame_deframer #(
   parameter int MAX_GRID_WIDTH  = 64,
   parameter int MAX_GRID_HEIGHT = 64
) (
   input  logic        clock,
   input  logic        reset,
   sgfd_req_if.sink    req_bus,
   sgfd_rsp_if.source  rsp_bus
);

   sgfd_pkg::sgfd_cmd_type  cmd;
   sgfd_pkg::sgfd_stat_type stat;

   // Controller: phase machine; hold the byte channel while a result waits
   // or the divider runs, advance on each examined byte.
   sgfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Datapath: token values, grid geometry, row counters, the 32-bit byte
   // sum for the checksum, the divider and the result register.
   sgfd_dpath #(
      .MAX_GRID_WIDTH  (MAX_GRID_WIDTH),
      .MAX_GRID_HEIGHT (MAX_GRID_HEIGHT)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_data_byte (req_bus.data_byte),
      .rsp           (rsp_bus)
   );

endmodule

### hdl/sgfd_ctrl.sv
// -----------------------------------------------------------------------------
// Sensor grid deframer controller
// Framing phase machine: hunt, status tokens and grid rows.
// -----------------------------------------------------------------------------
module sgfd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  sgfd_pkg::sgfd_stat_type stat,
   output sgfd_pkg::sgfd_cmd_type  cmd
);

   typedef enum logic [1:0] {ST_WAIT, ST_EXEC, ST_DIV} state_type;
   typedef enum logic [2:0] {
      PH_HUNT, PH_SYNC_FF, PH_STAT_FF, PH_STAT_LINE,
      PH_TOKENS, PH_ROW_FF, PH_ROW_LINE, PH_ROW_DATA
   } phase_type;

   state_type st_ff, st_in;
   phase_type ph_ff, ph_in;
   logic [3:0] tidx_ff, tidx_in;
   logic [2:0] didx_ff, didx_in;

   always_comb begin
      st_in   = st_ff;
      ph_in   = ph_ff;
      tidx_in = tidx_ff;
      didx_in = didx_ff;
      cmd     = '0;
      cmd.token_index = tidx_ff;
      req_ready = (st_ff == ST_WAIT);
      unique case (st_ff)
         ST_WAIT: begin
            if (req_valid) begin
               cmd.load_byte = 1'b1;
               st_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (!stat.out_busy) begin
               st_in = ST_WAIT;
               unique case (ph_ff)
                  PH_HUNT: begin
                     if (stat.is_ff) ph_in = PH_SYNC_FF;
                  end
                  PH_SYNC_FF: begin
                     if (stat.is_zero) begin
                        ph_in   = PH_TOKENS;
                        tidx_in = '0;
                        didx_in = '0;
                     end else if (!stat.is_ff) begin
                        ph_in = PH_HUNT;
                     end
                  end
                  PH_STAT_FF, PH_ROW_FF: begin
                     if (!stat.is_ff) begin
                        cmd.sync_lost = 1'b1;
                        ph_in = PH_HUNT;
                     end else begin
                        ph_in = (ph_ff == PH_STAT_FF) ? PH_STAT_LINE : PH_ROW_LINE;
                     end
                  end
                  PH_STAT_LINE: begin
                     if (!stat.is_zero) begin
                        cmd.sync_lost = 1'b1;
                        ph_in = PH_HUNT;
                     end else begin
                        ph_in   = PH_TOKENS;
                        tidx_in = '0;
                        didx_in = '0;
                     end
                  end
                  PH_TOKENS: begin
                     if (didx_ff == 3'd0) begin
                        if (!stat.tag_ok) begin
                           cmd.sync_lost = 1'b1;
                           ph_in = PH_HUNT;
                        end else begin
                           cmd.tag_start = 1'b1;
                           didx_in = 3'd1;
                        end
                     end else if (!stat.hex_ok) begin
                        cmd.sync_lost = 1'b1;
                        ph_in = PH_HUNT;
                     end else begin
                        cmd.digit = 1'b1;
                        if (didx_ff < sgfd_pkg::HEX_DIGITS) begin
                           didx_in = didx_ff + 3'd1;
                        end else begin
                           cmd.digit_last = 1'b1;
                           if (stat.tok_err) begin
                              cmd.sync_lost = 1'b1;
                              ph_in = PH_HUNT;
                           end else if (stat.tok_finish) begin
                              cmd.div_start = 1'b1;
                              st_in = ST_DIV;
                              ph_in = PH_ROW_FF;
                           end else begin
                              tidx_in = tidx_ff + 4'd1;
                              didx_in = '0;
                           end
                        end
                     end
                  end
                  PH_ROW_LINE: begin
                     if (!stat.line_ok) begin
                        cmd.sync_lost = 1'b1;
                        ph_in = PH_HUNT;
                     end else begin
                        cmd.row_line = 1'b1;
                        if (stat.vpr_zero) begin
                           cmd.row_end = 1'b1;
                           ph_in = stat.line_last ? PH_STAT_FF : PH_ROW_FF;
                        end else begin
                           ph_in = PH_ROW_DATA;
                        end
                     end
                  end
                  PH_ROW_DATA: begin
                     cmd.pixel = 1'b1;
                     if (stat.data_last) begin
                        cmd.row_end = 1'b1;
                        ph_in = stat.line_last ? PH_STAT_FF : PH_ROW_FF;
                     end
                  end
                  default: ph_in = PH_HUNT;
               endcase
               if (cmd.sync_lost) begin
                  tidx_in = '0;
                  didx_in = '0;
               end
            end
         end
         ST_DIV: begin
            if (!stat.div_busy && !stat.out_busy) begin
               cmd.status_emit = 1'b1;
               st_in = ST_WAIT;
            end
         end
         default: st_in = ST_WAIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= ST_WAIT;
         ph_ff   <= PH_HUNT;
         tidx_ff <= '0;
         didx_ff <= '0;
      end else begin
         st_ff   <= st_in;
         ph_ff   <= ph_in;
         tidx_ff <= tidx_in;
         didx_ff <= didx_in;
      end
   end

endmodule

### hdl/sgfd_dpath.sv
// -----------------------------------------------------------------------------
// Sensor grid deframer datapath
// Byte register, hex token assembly, status fields, grid size, row counters,
// byte sum, width divider and the result register.
// -----------------------------------------------------------------------------
module sgfd_dpath #(
   parameter int MAX_GRID_WIDTH  = 64,
   parameter int MAX_GRID_HEIGHT = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  sgfd_pkg::sgfd_cmd_type  cmd,
   output sgfd_pkg::sgfd_stat_type stat,
   input  logic [7:0]              req_data_byte,
   sgfd_rsp_if.source              rsp
);

   localparam int WW = $clog2(MAX_GRID_WIDTH + 1);
   localparam int HW = $clog2(MAX_GRID_HEIGHT + 1);
   localparam int CW = $clog2(WW + 1);

   function automatic logic [4:0] hex_decode(input logic [7:0] b);
      logic [4:0] r;
      r = '0;
      if (b >= 8'h30 && b <= 8'h39) r = {1'b1, 4'(b - 8'h30)};
      else if (b >= 8'h41 && b <= 8'h46) r = {1'b1, 4'(b - 8'h37)};
      else if (b >= 8'h61 && b <= 8'h66) r = {1'b1, 4'(b - 8'h57)};
      return r;
   endfunction

   logic [7:0]    byte_ff;
   logic [15:0]   acc_ff;
   logic [15:0]   version_ff;
   logic [15:0]   fw_status_ff, ctrl_id_ff, fw_mode_ff, rate_ff, frame_ff;
   logic [WW-1:0] width_ff;
   logic [HW-1:0] height_ff;
   logic [15:0]   mux_count_ff, mux_phase_ff;
   logic [WW-1:0] vpr_ff, data_count_ff;
   logic [6:0]    line_ff;
   logic [31:0]   sum_ff;
   logic          first_ff;
   logic [15:0]   ck_ff;
   logic          has_ck_ff;
   logic [16:0]   rem_ff;
   logic [WW-1:0] quo_ff;
   logic [CW-1:0] div_cnt_ff;
   logic          out_valid_ff;
   logic [2:0]    out_kind_ff;
   logic [5:0]    out_row_ff, out_col_ff;
   logic [7:0]    out_pixel_ff;

   logic [4:0]    hex;
   logic [15:0]   acc_next;
   logic [7:0]    cur_tag;
   logic          w_bad, h_bad;
   logic [WW-1:0] vpr_next;
   logic [5:0]    col;
   logic [2:0]    status_kind;
   logic [16:0]   rem_sh;
   logic          fits;
   logic          emit;
   logic          out_busy;

   assign hex      = hex_decode(byte_ff);
   assign acc_next = {acc_ff[11:0], hex[3:0]};
   assign cur_tag  = sgfd_pkg::tag_for(version_ff, cmd.token_index);
   assign w_bad    = (acc_next == 16'd0) || (acc_next > 16'(MAX_GRID_WIDTH));
   assign h_bad    = (acc_next == 16'd0) || (acc_next > 16'(MAX_GRID_HEIGHT));
   assign vpr_next = (mux_count_ff == 16'd0) ? width_ff : quo_ff;
   assign col      = (mux_count_ff == 16'd0) ? 6'(data_count_ff)
                   : 6'(mux_phase_ff[5:0] + 6'(6'(data_count_ff) * mux_count_ff[5:0]));
   assign rem_sh   = {rem_ff[15:0], quo_ff[WW-1]};
   assign fits     = rem_sh >= {1'b0, mux_count_ff};
   assign out_busy = out_valid_ff && !rsp.ready;
   assign emit     = cmd.sync_lost || cmd.pixel || cmd.status_emit;

   always_comb begin
      if (first_ff) status_kind = sgfd_pkg::KIND_UNCHECKED;
      else if (mux_phase_ff == 16'd0 && has_ck_ff)
         status_kind = (sum_ff == {16'd0, ck_ff}) ? sgfd_pkg::KIND_ACCEPT
                                                  : sgfd_pkg::KIND_CK_DROP;
      else status_kind = sgfd_pkg::KIND_UNCHECKED;
   end

   always_comb begin
      stat.is_ff      = (byte_ff == sgfd_pkg::BYTE_SYNC);
      stat.is_zero    = (byte_ff == sgfd_pkg::BYTE_ZERO);
      stat.tag_ok     = (cur_tag != sgfd_pkg::TAG_NONE) && (byte_ff == cur_tag);
      stat.hex_ok     = hex[4];
      stat.tok_err    = ((cur_tag == sgfd_pkg::TAG_V) && (acc_next > sgfd_pkg::VERSION_MUX))
                     || ((cur_tag == sgfd_pkg::TAG_W) && w_bad)
                     || ((cur_tag == sgfd_pkg::TAG_H) && h_bad)
                     || ((cur_tag == sgfd_pkg::TAG_XL) && (mux_count_ff != 16'd0)
                         && (acc_next >= mux_count_ff));
      stat.tok_finish = ((cur_tag == sgfd_pkg::TAG_V) && (acc_next < sgfd_pkg::VERSION_BASE))
                     || (cur_tag == sgfd_pkg::TAG_C);
      stat.line_ok    = (byte_ff == {1'b0, line_ff}) && (line_ff != 7'd0);
      stat.vpr_zero   = (vpr_ff == '0);
      stat.data_last  = ({1'b0, data_count_ff} + 1'b1) >= {1'b0, vpr_ff};
      stat.line_last  = 9'(line_ff) >= 9'(height_ff);
      stat.div_busy   = (div_cnt_ff != '0);
      stat.out_busy   = out_busy;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_byte) byte_ff <= req_data_byte;
      if (emit) begin
         out_kind_ff  <= cmd.pixel ? sgfd_pkg::KIND_PIXEL
                       : cmd.sync_lost ? sgfd_pkg::KIND_SYNC_LOST : status_kind;
         out_row_ff   <= cmd.pixel ? 6'(line_ff - 7'd1) : 6'd0;
         out_col_ff   <= cmd.pixel ? col : 6'd0;
         out_pixel_ff <= cmd.pixel ? byte_ff : 8'd0;
      end
      if (reset) begin
         acc_ff        <= '0;
         version_ff    <= '0;
         fw_status_ff  <= '0;
         ctrl_id_ff    <= '0;
         fw_mode_ff    <= '0;
         rate_ff       <= '0;
         frame_ff      <= '0;
         width_ff      <= '0;
         height_ff     <= '0;
         mux_count_ff  <= '0;
         mux_phase_ff  <= '0;
         vpr_ff        <= '0;
         data_count_ff <= '0;
         line_ff       <= '0;
         sum_ff        <= '0;
         first_ff      <= 1'b1;
         ck_ff         <= '0;
         has_ck_ff     <= 1'b0;
         rem_ff        <= '0;
         quo_ff        <= '0;
         div_cnt_ff    <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (cmd.tag_start) acc_ff <= '0;
         if (cmd.digit) acc_ff <= acc_next;
         // store the finished token
         if (cmd.digit && cmd.digit_last) begin
            case (cur_tag)
               sgfd_pkg::TAG_V: begin
                  version_ff <= acc_next;
                  if (acc_next < sgfd_pkg::VERSION_BASE) begin
                     width_ff  <= WW'(sgfd_pkg::LEGACY_WIDTH);
                     height_ff <= HW'(sgfd_pkg::LEGACY_HEIGHT);
                     has_ck_ff <= 1'b0;
                  end
               end
               sgfd_pkg::TAG_S: fw_status_ff <= acc_next;
               sgfd_pkg::TAG_I: ctrl_id_ff   <= acc_next;
               sgfd_pkg::TAG_M: fw_mode_ff   <= acc_next;
               sgfd_pkg::TAG_F: rate_ff      <= acc_next;
               sgfd_pkg::TAG_N: frame_ff     <= acc_next;
               sgfd_pkg::TAG_W: if (!w_bad) width_ff  <= WW'(acc_next);
               sgfd_pkg::TAG_H: if (!h_bad) height_ff <= HW'(acc_next);
               sgfd_pkg::TAG_X: mux_count_ff <= acc_next;
               sgfd_pkg::TAG_XL: mux_phase_ff <= acc_next;
               sgfd_pkg::TAG_C: begin
                  ck_ff     <= acc_next;
                  has_ck_ff <= 1'b1;
               end
               default: ;
            endcase
         end
         if (cmd.row_line) data_count_ff <= '0;
         if (cmd.pixel) begin
            sum_ff        <= sum_ff + {24'd0, byte_ff};
            data_count_ff <= data_count_ff + 1'b1;
         end
         if (cmd.row_end) line_ff <= stat.line_last ? 7'd0 : line_ff + 7'd1;
         // restoring divide of width by mux count, one quotient bit a cycle;
         // a legacy line divides the fixed width that lands on this same edge
         if (cmd.div_start) begin
            rem_ff     <= '0;
            quo_ff     <= (cur_tag == sgfd_pkg::TAG_V) ? WW'(sgfd_pkg::LEGACY_WIDTH)
                                                      : width_ff;
            div_cnt_ff <= CW'(WW);
         end else if (div_cnt_ff != '0) begin
            rem_ff     <= fits ? rem_sh - {1'b0, mux_count_ff} : rem_sh;
            quo_ff     <= {quo_ff[WW-2:0], fits};
            div_cnt_ff <= div_cnt_ff - 1'b1;
         end
         if (cmd.status_emit) begin
            vpr_ff   <= vpr_next;
            first_ff <= 1'b0;
            sum_ff   <= '0;
            line_ff  <= 7'd1;
         end
         if (cmd.sync_lost) begin
            first_ff      <= 1'b1;
            sum_ff        <= '0;
            width_ff      <= '0;
            height_ff     <= '0;
            line_ff       <= '0;
            vpr_ff        <= '0;
            data_count_ff <= '0;
         end
         out_valid_ff <= emit || (out_valid_ff && !rsp.ready);
      end
   end

   assign rsp.valid            = out_valid_ff;
   assign rsp.kind             = out_kind_ff;
   assign rsp.row              = out_row_ff;
   assign rsp.column           = out_col_ff;
   assign rsp.pixel            = out_pixel_ff;
   assign rsp.frame_number     = frame_ff;
   assign rsp.firmware_version = version_ff;
   assign rsp.firmware_status  = fw_status_ff;
   assign rsp.controller_id    = ctrl_id_ff;
   assign rsp.firmware_mode    = fw_mode_ff;
   assign rsp.frame_rate       = rate_ff;
   assign rsp.grid_width       = 7'(width_ff);
   assign rsp.grid_height      = 7'(height_ff);

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.sync_lost, cmd.pixel, cmd.status_emit}))
      else $error("more than one result source in a cycle");
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      emit |-> !out_busy)
      else $error("result loaded over an untaken beat");
   a_pixel_vpr: assert property (@(posedge clock) disable iff (reset)
      cmd.pixel |-> (vpr_ff != '0))
      else $error("pixel in a row with no values");
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      cmd.status_emit |-> (div_cnt_ff == '0))
      else $error("status event before divide finished");
   a_div_run: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> (div_cnt_ff == CW'(WW)))
      else $error("divider did not start");

endmodule

### bench/sgfd_checker.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// Sensor grid deframer checker
// Watches the byte and result channels, runs a behavioral deframer on every
// accepted byte and compares each result beat field by field in order.
// -----------------------------------------------------------------------------
module sgfd_checker (
   input  logic     clock,
   input  logic     reset,
   sgfd_req_if      req_bus,
   sgfd_rsp_if      rsp_bus,
   output int       fail_count,
   output int       pending_count,
   output int       byte_count,
   output int       result_count,
   output int       kind_seen [0:4]
);

   typedef enum logic [2:0] {
      P_HUNT, P_SYNC_FF, P_STAT_FF, P_STAT_LINE, P_TOKENS, P_ROW_FF, P_ROW_LINE, P_ROW_DATA
   } phase_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [5:0]  row;
      logic [5:0]  column;
      logic [7:0]  pixel;
      logic [15:0] frame_number;
      logic [15:0] firmware_version;
      logic [15:0] firmware_status;
      logic [15:0] controller_id;
      logic [15:0] firmware_mode;
      logic [15:0] frame_rate;
      logic [6:0]  grid_width;
      logic [6:0]  grid_height;
   } beat_type;

   beat_type    want_q[$];
   phase_type   ph;
   int unsigned tok_idx, dig_idx, hex_acc, line_no, version, width, height;
   int unsigned mux_cnt, mux_ph, per_row, data_cnt, byte_sum;
   bit          first_frame;
   int unsigned fields [0:4];

   function automatic logic [7:0] expected_tag(int unsigned idx);
      string lay;
      if (idx == 0) return sgfd_pkg::TAG_V;
      if (version == 260) lay = "VSIMFWHNC";
      else if (version == 261) lay = "VSIMFWHGNC";
      else if (version == 262) lay = "VSIMFWHGNXxC";
      else return sgfd_pkg::TAG_NONE;
      if (idx >= lay.len()) return sgfd_pkg::TAG_NONE;
      return lay[idx];
   endfunction

   function automatic int hex_digit(logic [7:0] b);
      if (b >= "0" && b <= "9") return int'(b) - int'("0");
      if (b >= "A" && b <= "F") return int'(b) - int'("A") + 10;
      if (b >= "a" && b <= "f") return int'(b) - int'("a") + 10;
      return -1;
   endfunction

   task automatic push_beat(logic [2:0] k, int unsigned r, int unsigned c, int unsigned p);
      beat_type e;
      e.kind = k; e.row = r[5:0]; e.column = c[5:0]; e.pixel = p[7:0];
      e.frame_number = fields[4][15:0]; e.firmware_version = version[15:0];
      e.firmware_status = fields[0][15:0]; e.controller_id = fields[1][15:0];
      e.firmware_mode = fields[2][15:0]; e.frame_rate = fields[3][15:0];
      e.grid_width = width[6:0]; e.grid_height = height[6:0];
      want_q.push_back(e);
   endtask

   task automatic lose_sync();
      ph = P_HUNT; first_frame = 1; byte_sum = 0; width = 0; height = 0;
      line_no = 0; tok_idx = 0; dig_idx = 0; hex_acc = 0; per_row = 0; data_cnt = 0;
      push_beat(sgfd_pkg::KIND_SYNC_LOST, 0, 0, 0);
   endtask

   task automatic close_status(bit has_ck, int unsigned ck);
      logic [2:0] k;
      per_row = mux_cnt != 0 ? width / mux_cnt : width;
      if (first_frame) begin
         first_frame = 0; k = sgfd_pkg::KIND_UNCHECKED;
      end else if (mux_ph == 0 && has_ck) begin
         k = (byte_sum == ck) ? sgfd_pkg::KIND_ACCEPT : sgfd_pkg::KIND_CK_DROP;
      end else begin
         k = sgfd_pkg::KIND_UNCHECKED;
      end
      byte_sum = 0; line_no = 1; ph = P_ROW_FF;
      push_beat(k, 0, 0, 0);
   endtask

   task automatic close_row();
      if (line_no >= height) begin
         line_no = 0; ph = P_STAT_FF;
      end else begin
         line_no = (line_no + 1) & 127; ph = P_ROW_FF;
      end
   endtask

   // Store a completed token; return 1 if it ended the line or broke sync
   task automatic take_token(logic [7:0] tag, int unsigned v, output bit ended);
      ended = 1;
      case (tag)
         sgfd_pkg::TAG_V: begin
            version = v;
            if (v < 260) begin
               width = 20; height = 10; close_status(0, 0); return;
            end
            if (v > 262) begin
               lose_sync(); return;
            end
         end
         sgfd_pkg::TAG_S: fields[0] = v;
         sgfd_pkg::TAG_I: fields[1] = v;
         sgfd_pkg::TAG_M: fields[2] = v;
         sgfd_pkg::TAG_F: fields[3] = v;
         sgfd_pkg::TAG_N: fields[4] = v;
         sgfd_pkg::TAG_W: begin
            if (v == 0 || v > 64) begin
               lose_sync(); return;
            end
            width = v;
         end
         sgfd_pkg::TAG_H: begin
            if (v == 0 || v > 64) begin
               lose_sync(); return;
            end
            height = v;
         end
         sgfd_pkg::TAG_X: mux_cnt = v;
         sgfd_pkg::TAG_XL: begin
            mux_ph = v;
            if (mux_cnt != 0 && v >= mux_cnt) begin
               lose_sync(); return;
            end
         end
         sgfd_pkg::TAG_C: begin
            close_status(1, v); return;
         end
         default: ;
      endcase
      ended = 0;
      tok_idx = (tok_idx + 1) & 15; dig_idx = 0; hex_acc = 0;
   endtask

   task automatic deframe_byte(logic [7:0] b);
      int          d;
      bit          ended;
      int unsigned col;
      case (ph)
         P_HUNT: if (b == sgfd_pkg::BYTE_SYNC) ph = P_SYNC_FF;
         P_SYNC_FF: begin
            if (b == sgfd_pkg::BYTE_ZERO) begin
               line_no = 0; tok_idx = 0; dig_idx = 0; hex_acc = 0; ph = P_TOKENS;
            end else if (b != sgfd_pkg::BYTE_SYNC) begin
               ph = P_HUNT;
            end
         end
         P_STAT_FF, P_ROW_FF: begin
            if (b != sgfd_pkg::BYTE_SYNC) lose_sync();
            else ph = (ph == P_STAT_FF) ? P_STAT_LINE : P_ROW_LINE;
         end
         P_STAT_LINE: begin
            if (b != sgfd_pkg::BYTE_ZERO) lose_sync();
            else begin
               tok_idx = 0; dig_idx = 0; hex_acc = 0; ph = P_TOKENS;
            end
         end
         P_TOKENS: begin
            if (dig_idx == 0) begin
               if (expected_tag(tok_idx) == sgfd_pkg::TAG_NONE ||
                   b != expected_tag(tok_idx))
                  lose_sync();
               else begin
                  dig_idx = 1; hex_acc = 0;
               end
            end else begin
               d = hex_digit(b);
               if (d < 0) lose_sync();
               else begin
                  hex_acc = ((hex_acc << 4) | d) & 16'hFFFF;
                  if (dig_idx < 4) dig_idx++;
                  else take_token(expected_tag(tok_idx), hex_acc, ended);
               end
            end
         end
         P_ROW_LINE: begin
            if (b != line_no || line_no == 0) lose_sync();
            else begin
               data_cnt = 0;
               if (per_row == 0) close_row();
               else ph = P_ROW_DATA;
            end
         end
         default: begin
            col = mux_cnt != 0 ? mux_ph + data_cnt * mux_cnt : data_cnt;
            push_beat(sgfd_pkg::KIND_PIXEL, line_no - 1, col, b);
            byte_sum += b;
            data_cnt++;
            if (data_cnt >= per_row) close_row();
         end
      endcase
   endtask

   always @(posedge clock) begin
      beat_type got, want;
      if (reset) begin
         ph = P_HUNT; tok_idx = 0; dig_idx = 0; hex_acc = 0; line_no = 0; version = 0;
         width = 0; height = 0; mux_cnt = 0; mux_ph = 0; per_row = 0; data_cnt = 0;
         byte_sum = 0; first_frame = 1;
         for (int i = 0; i < 5; i++) fields[i] = 0;
         want_q.delete();
         fail_count <= 0; byte_count <= 0; result_count <= 0;
         for (int i = 0; i < 5; i++) kind_seen[i] <= 0;
      end else begin
         // Check the result side before predicting: a byte's result comes later
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = {rsp_bus.kind, rsp_bus.row, rsp_bus.column, rsp_bus.pixel,
                   rsp_bus.frame_number, rsp_bus.firmware_version, rsp_bus.firmware_status,
                   rsp_bus.controller_id, rsp_bus.firmware_mode, rsp_bus.frame_rate,
                   rsp_bus.grid_width, rsp_bus.grid_height};
            result_count <= result_count + 1;
            if (got.kind <= sgfd_pkg::KIND_SYNC_LOST)
               kind_seen[got.kind] <= kind_seen[got.kind] + 1;
            if (want_q.size() == 0) begin
               if (fail_count < 10) $display("%0t: unexpected result beat %h", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               want = want_q.pop_front();
               if (got !== want) begin
                  if (fail_count < 10) begin
                     $display("%0t: mismatch kind %0d/%0d row %0d/%0d col %0d/%0d pix %0d/%0d",
                              $time, want.kind, got.kind, want.row, got.row, want.column,
                              got.column, want.pixel, got.pixel);
                     $display("   expected %h\n   actual   %h", want, got);
                  end
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            deframe_byte(req_bus.data_byte);
            byte_count <= byte_count + 1;
         end
      end
      pending_count <= want_q.size();
   end
endmodule

### bench/tb_sensor_grid_frame_deframer.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// Sensor grid deframer testbench
// Sends directed and random byte streams made mostly of well-formed status
// lines and rows of every firmware layout, mixed with broken framing and
// noise, with random idling on both sides and one long result stall.
// -----------------------------------------------------------------------------
module tb_sensor_grid_frame_deframer;

   localparam int TOTAL_BYTES = 1000;
   localparam int STALL_LIMIT = 20000;

   logic clock;
   logic reset;
   int   fail_count, pending_count, byte_count, result_count;
   int   kind_seen [0:4];
   int   idle_cycles;
   bit   timed_out;
   bit   steady_send, steady_recv;
   bit   hold_results;
   logic [7:0] stream_q[$];

   sgfd_req_if req_bus ();
   sgfd_rsp_if rsp_bus ();

   sensor_grid_frame_deframer uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   sgfd_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .rsp_bus       (rsp_bus),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .byte_count    (byte_count),
      .result_count  (result_count),
      .kind_seen     (kind_seen)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Random idling on the result side; none during the steady stretch, hold under pressure
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= !hold_results && (steady_recv || $urandom_range(99) >= 19);
      end
   end

   // Count a long result stall in its own process while bytes keep coming
   task automatic stall_results(int cycles);
      hold_results = 1'b1;
      repeat (cycles) @(posedge clock);
      hold_results = 1'b0;
   endtask

   // ---- stream builders ----------------------------------------------------
   function automatic logic [7:0] hex_char(logic [3:0] n);
      if (n < 10) return "0" + 8'(n);
      return ($urandom_range(1) ? "A" : "a") + 8'(n) - 8'd10;
   endfunction

   task automatic add_token(logic [7:0] tag, int unsigned v);
      stream_q.push_back(tag);
      for (int i = 3; i >= 0; i--) stream_q.push_back(hex_char(v[i*4 +: 4]));
   endtask

   // Append one status line; ck is the checksum of the preceding rows
   task automatic add_status(int unsigned ver, int unsigned w, int unsigned h,
                             int unsigned mcnt, int unsigned mph, int unsigned ck,
                             bit with_head);
      if (with_head) begin
         stream_q.push_back(sgfd_pkg::BYTE_SYNC);
         stream_q.push_back(sgfd_pkg::BYTE_ZERO);
      end
      add_token(sgfd_pkg::TAG_V, ver);
      if (ver < 260 || ver > 262) return;
      add_token(sgfd_pkg::TAG_S, $urandom); add_token(sgfd_pkg::TAG_I, $urandom);
      add_token(sgfd_pkg::TAG_M, $urandom_range(2, 1)); add_token(sgfd_pkg::TAG_F, $urandom);
      add_token(sgfd_pkg::TAG_W, w); add_token(sgfd_pkg::TAG_H, h);
      if (ver >= 261) add_token(sgfd_pkg::TAG_G, $urandom);
      add_token(sgfd_pkg::TAG_N, $urandom);
      if (ver == 262) begin
         add_token(sgfd_pkg::TAG_X, mcnt); add_token(sgfd_pkg::TAG_XL, mph);
      end
      add_token(sgfd_pkg::TAG_C, ck);
   endtask

   // Append rows; returns the byte sum
   task automatic add_rows(int unsigned h, int unsigned per_row, bit extreme,
                           output int unsigned sum);
      logic [7:0] b;
      sum = 0;
      for (int r = 1; r <= h; r++) begin
         stream_q.push_back(sgfd_pkg::BYTE_SYNC);
         stream_q.push_back(r[7:0]);
         for (int i = 0; i < per_row; i++) begin
            b = extreme ? (i[0] ? 8'hFF : 8'h00) : 8'($urandom);
            stream_q.push_back(b);
            sum += b;
         end
      end
   endtask

   // A whole frame sequence: status lines with rows between, in one layout
   task automatic add_session(int unsigned frames);
      int unsigned ver, w, h, mcnt, mph, per_row, sum;
      int unsigned pick;
      pick = $urandom_range(9);
      ver  = pick < 2 ? $urandom_range(259) : 260 + $urandom_range(2);
      w = $urandom_range(100) < 10 ? 64 : $urandom_range(6, 1);
      h = $urandom_range(100) < 10 ? 64 : $urandom_range(3, 1);
      if (ver < 260) begin
         w = 20; h = 10;
      end
      mcnt = 0; mph = 0;
      if (ver == 262 && $urandom_range(1)) begin
         mcnt = $urandom_range(3, 1);
         mph  = $urandom_range(100) < 70 ? 0 : $urandom_range(mcnt - 1);
      end
      // legacy frames are big; keep them to one
      if (ver < 260 && frames > 2) frames = 2;
      if (w * h > 64) frames = 1;
      per_row = mcnt != 0 ? w / mcnt : w;
      sum = $urandom;
      for (int f = 0; f < frames; f++) begin
         add_status(ver, w, h, mcnt, mph,
                    ($urandom_range(100) < 80) ? sum : sum + 1, f == 0);
         add_rows(h, per_row, 0, sum);
         stream_q.push_back(sgfd_pkg::BYTE_SYNC);
         stream_q.push_back(sgfd_pkg::BYTE_ZERO);
      end
      // close the last line or break it
      case ($urandom_range(3))
         0: add_status(ver, w, h, mcnt, mph, sum, 0);
         1: stream_q.push_back(8'($urandom));
         2: add_token(sgfd_pkg::TAG_V, 263 + $urandom_range(65272));
         default: begin
            stream_q.push_back(sgfd_pkg::TAG_V);
            stream_q.push_back("g");
         end
      endcase
   endtask

   task automatic send_stream();
      while (stream_q.size() != 0) begin
         if (!steady_send && $urandom_range(99) < 19) begin
            req_bus.valid <= 1'b0;
            @(posedge clock);
         end else begin
            req_bus.valid     <= 1'b1;
            req_bus.data_byte <= stream_q.pop_front();
            do @(posedge clock); while (!req_bus.ready);
         end
      end
      req_bus.valid <= 1'b0;
   endtask

   // Directed part: extremes, all layouts, each error path
   task automatic build_directed();
      int unsigned sum;
      stream_q.push_back(8'h00); stream_q.push_back(sgfd_pkg::BYTE_SYNC);
      stream_q.push_back(8'h01);
      add_status(0, 20, 10, 0, 0, 0, 1);
      stream_q.push_back(8'h12);                          // missing row 0xFF
      add_status(262, 64, 1, 0, 0, 0, 1);
      add_rows(1, 64, 1, sum);
      add_status(262, 64, 1, 0, 0, sum, 1);               // accepted
      add_rows(1, 64, 1, sum);
      add_status(262, 64, 1, 0, 0, sum + 1, 1);           // checksum drop
      stream_q.push_back(sgfd_pkg::BYTE_SYNC); stream_q.push_back(8'd2); // wrong line
      add_status(262, 4, 2, 2, 1, 0, 1);
      add_rows(2, 2, 0, sum);
      add_status(262, 4, 2, 2, 1, sum, 1);                // mux phase nonzero
      stream_q.push_back(8'h7F);                          // missing row 0xFF
      add_status(262, 4, 1, 5, 0, 0, 1);                  // mux larger than width
      stream_q.push_back(sgfd_pkg::BYTE_SYNC); stream_q.push_back(8'd1);
      add_status(262, 4, 1, 0, 0, 0, 1);                  // x equal to X
      stream_q.push_back(sgfd_pkg::BYTE_SYNC); stream_q.push_back(sgfd_pkg::BYTE_ZERO);
      add_token(sgfd_pkg::TAG_V, 262); add_token(sgfd_pkg::TAG_S, 16'hFFFF);
      add_token(sgfd_pkg::TAG_I, 0); add_token(sgfd_pkg::TAG_M, 1);
      add_token(sgfd_pkg::TAG_F, 0); add_token(sgfd_pkg::TAG_W, 4);
      add_token(sgfd_pkg::TAG_H, 1); add_token(sgfd_pkg::TAG_G, 0);
      add_token(sgfd_pkg::TAG_N, 16'hFFFF);
      add_token(sgfd_pkg::TAG_X, 2); add_token(sgfd_pkg::TAG_XL, 2);
      stream_q.push_back(sgfd_pkg::BYTE_SYNC); stream_q.push_back(sgfd_pkg::BYTE_ZERO);
      add_token(sgfd_pkg::TAG_V, 260); add_token(sgfd_pkg::TAG_W, 0);   // wrong tag
      stream_q.push_back(sgfd_pkg::BYTE_SYNC); stream_q.push_back(sgfd_pkg::BYTE_ZERO);
      add_token(sgfd_pkg::TAG_V, 16'hFFFF);               // version too high
      add_status(261, 0, 1, 0, 0, 0, 1);                  // zero width
      add_status(261, 65, 1, 0, 0, 0, 1);                 // width over max
      add_status(260, 3, 0, 0, 0, 0, 1);                  // zero height
      add_status(260, 3, 65, 0, 0, 0, 1);                 // height over max
      stream_q.push_back(sgfd_pkg::BYTE_SYNC); stream_q.push_back(sgfd_pkg::BYTE_ZERO);
      stream_q.push_back(sgfd_pkg::TAG_V); stream_q.push_back(":");  // non-hex digit
      stream_q.push_back(sgfd_pkg::BYTE_SYNC); stream_q.push_back(sgfd_pkg::BYTE_ZERO);
      stream_q.push_back(sgfd_pkg::TAG_V); stream_q.push_back("G");
   endtask

   // Stop the run if the channels go quiet
   initial begin
      idle_cycles = 0;
      timed_out   = 1'b0;
      forever begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             reset || hold_results)
            idle_cycles = 0;
         else if (pending_count != 0 || req_bus.valid)
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.data_byte = 8'h00;
      steady_send       = 1'b1;
      steady_recv       = 1'b1;
      hold_results      = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part runs as one long stretch with no idling on either side
      build_directed();
      send_stream();
      steady_send = 1'b0;
      steady_recv = 1'b0;

      // Hold results off for a long stretch while bytes keep arriving
      fork
         stall_results(300);
         begin
            add_session(3);
            send_stream();
         end
      join

      // Random part: mostly well-formed sessions, some raw noise
      do begin
         steady_send = ($urandom_range(9) == 0);
         steady_recv = steady_send;
         if ($urandom_range(9) < 8) add_session($urandom_range(4, 1));
         else repeat ($urandom_range(12, 1))
            stream_q.push_back($urandom_range(3) == 0 ? sgfd_pkg::BYTE_SYNC
                                                      : 8'($urandom));
         send_stream();
      end while (byte_count < TOTAL_BYTES);
      steady_send = 1'b0;
      steady_recv = 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("%0d bytes, %0d results: pixel %0d accepted %0d drop %0d unchecked %0d",
               byte_count, result_count, kind_seen[0], kind_seen[1], kind_seen[2],
               kind_seen[3]);
      $display("sync lost %0d; layouts legacy, 260, 261 and 262 with and without mux",
               kind_seen[4]);
      if (fail_count == 0 && pending_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
